@@ rtl/digest_dedup_clock_cache_assert.svh @@
// Assertion macros for the digest dedup clock cache checker.
`ifndef DIGEST_DEDUP_CLOCK_CACHE_ASSERT_SVH
`define DIGEST_DEDUP_CLOCK_CACHE_ASSERT_SVH
`define DDC_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DDC_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`endif

@@ rtl/ddcc_pkg.sv @@
// Shared types and constants for the digest dedup clock cache.
package ddcc_pkg;
    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_DEC,
        ST_PICK_RD,
        ST_PICK,
        ST_REL,
        ST_WR,
        ST_OUT
    } t_state;

    typedef enum logic [0:0] {
        REQ_LOOKUP = 1'b0,
        REQ_INSERT = 1'b1
    } t_req;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned EVICT_W = 3;
endpackage

@@ rtl/ddcc_if.sv @@
// Valid/ready channel interfaces for requests and results.
interface ddcc_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [63:0] digest_w0;
    logic [63:0] digest_w1;
    logic [63:0] digest_w2;
    logic [63:0] digest_w3;
    modport source (output valid, req_type, digest_w0, digest_w1, digest_w2, digest_w3,
                    input ready);
    modport sink (input valid, req_type, digest_w0, digest_w1, digest_w2, digest_w3,
                  output ready);
endinterface

interface ddcc_rsp_if;
    logic       valid;
    logic       ready;
    logic       hit;
    logic       stored;
    logic [2:0] evicted_count;
    modport source (output valid, hit, stored, evicted_count, input ready);
    modport sink (input valid, hit, stored, evicted_count, output ready);
endinterface

@@ rtl/digest_dedup_clock_cache.sv @@
// Digest dedup filter: set-associative tag store with clock replacement.
// One transaction at a time. After reset a clearing pass initializes every
// set's control row; ready stays low during it. A request then reads its
// set's control row and scans the WAYS tags one per cycle through a single
// shared 256-bit comparator fed by the tag memory read port, stopping early
// on a hit; the next request is taken the cycle after the result is. A
// full-set insert then steps the clock hand one way per cycle (at most
// 2*WAYS+1 steps per pick, up to WAYS/2+1 picks). The result waits in an
// output register; ready is low until taken.
module digest_dedup_clock_cache #(
    parameter int unsigned WAYS         = 8,
    parameter int unsigned SET_BITS     = 12,
    parameter int unsigned DIGEST_BYTES = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ddcc_req_if.sink   i_req,
    ddcc_rsp_if.source o_rsp
);
    localparam int unsigned WB    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned CW    = $clog2(WAYS + 1);
    localparam int unsigned NSETS = 2**SET_BITS;
    localparam int unsigned SW    = $clog2(2 * WAYS + 2);
    localparam int unsigned TW    = 4 * ddcc_pkg::WORD_W;
    localparam int unsigned EVICT_W_L = $clog2(WAYS / 2 + 2);

    typedef logic [WB-1:0] t_way;
    typedef struct packed {
        logic [WAYS-1:0]      used;
        logic [WAYS-1:0]      refb;
        logic [WAYS*WB-1:0]   uord;
        logic [WAYS*WB-1:0]   ford;
        logic [CW-1:0]        cnt;
        t_way                 hand;
        logic                 hv;
    } t_row;

    function automatic logic [63:0] wmask(input int k);
        int v;
        v = DIGEST_BYTES - 8 * k;
        if (v >= 8) return '1;
        if (v <= 0) return '0;
        return ~64'd0 << (64 - 8 * v);
    endfunction

    function automatic t_row row_init();
        t_row r;
        r = '0;
        for (int w = 0; w < WAYS; w++) r.ford[w*WB +: WB] = WB'(w);
        return r;
    endfunction

    // Finds way w in the used order and returns the way after it (wrap to head).
    function automatic t_way next_after(input t_row r, input t_way w);
        t_way n;
        n = r.uord[0 +: WB];
        for (int p = 0; p < WAYS - 1; p++) begin
            if (CW'(p) + 1'b1 < r.cnt && r.uord[p*WB +: WB] == w &&
                r.cnt > CW'(p)) begin
                n = r.uord[(p+1)*WB +: WB];
            end
        end
        return n;
    endfunction

    function automatic t_row release_way(input t_row r, input t_way w);
        t_row o;
        logic fnd;
        logic [WAYS*WB-1:0] nu;
        o = r;
        fnd = 1'b0;
        nu = r.uord;
        for (int p = 0; p < WAYS; p++) begin
            if (CW'(p) < r.cnt && r.uord[p*WB +: WB] == w) fnd = 1'b1;
        end
        if (fnd) begin
            if (r.hv && r.hand == w) o.hand = next_after(r, w);
            for (int p = 0; p < WAYS - 1; p++) begin
                logic seen;
                seen = 1'b0;
                for (int q = 0; q <= p; q++)
                    if (CW'(q) < r.cnt && r.uord[q*WB +: WB] == w) seen = 1'b1;
                if (seen && CW'(p) + 1'b1 < r.cnt)
                    nu[p*WB +: WB] = r.uord[(p+1)*WB +: WB];
            end
            o.uord = nu;
            for (int p = 0; p < WAYS; p++)
                if (CW'(WAYS) - r.cnt == CW'(p)) o.ford[p*WB +: WB] = w;
            o.cnt = r.cnt - 1'b1;
            o.used[w] = 1'b0;
            if (r.cnt == CW'(1)) o.hv = 1'b0;
        end
        return o;
    endfunction

    function automatic t_row take_free(input t_row r, output t_way w);
        t_row o;
        o = r;
        w = r.ford[0 +: WB];
        for (int q = 0; q < WAYS - 1; q++)
            if (CW'(q) + 1'b1 < CW'(WAYS) - r.cnt)
                o.ford[q*WB +: WB] = r.ford[(q+1)*WB +: WB];
        for (int p = 0; p < WAYS; p++)
            if (r.cnt == CW'(p)) o.uord[p*WB +: WB] = w;
        o.cnt = r.cnt + 1'b1;
        o.used[w] = 1'b1;
        if (r.cnt == '0) begin
            o.hand = w;
            o.hv = 1'b1;
        end
        return o;
    endfunction

    ddcc_pkg::t_state r_state, n_state;
    t_row r_row, n_row;
    t_row r_ctl [NSETS];
    t_row r_ctl_q;
    logic [SET_BITS-1:0] r_clr;
    logic [SET_BITS-1:0] ctl_raddr;
    logic [SET_BITS-1:0] ctl_waddr;
    t_row ctl_wdata;
    logic [SET_BITS-1:0] r_set;
    logic [TW-1:0] r_tag;
    logic r_ins, n_ins;
    t_way r_way, n_way;
    t_way r_victim, n_victim;
    logic [SW-1:0] r_step, n_step;
    logic [EVICT_W_L-1:0] r_picks, n_picks;
    logic r_hit, n_hit, r_stored, n_stored;
    logic [ddcc_pkg::EVICT_W-1:0] r_ev, n_ev;
    logic r_ovalid, n_ovalid;
    logic [TW-1:0] tag_rd;
    logic tag_we;
    logic ctl_we;
    logic [TW-1:0] in_tag;

    assign in_tag = {i_req.digest_w0 & (~64'd0 >> SET_BITS) & wmask(0),
                     i_req.digest_w1 & wmask(1),
                     i_req.digest_w2 & wmask(2),
                     i_req.digest_w3 & wmask(3)};

    ddcc_tag_ram #(.AW(SET_BITS + WB), .DW(TW)) u_tags (
        .i_clk  (i_clk),
        .i_we   (tag_we),
        .i_waddr({r_set, n_victim}),
        .i_wdata(r_tag),
        .i_raddr({r_set, n_way}),
        .o_rdata(tag_rd)
    );

    assign ctl_raddr = (r_state == ddcc_pkg::ST_IDLE) ? i_req.digest_w0[63 -: SET_BITS] : r_set;
    assign ctl_waddr = (r_state == ddcc_pkg::ST_CLR) ? r_clr : r_set;
    assign ctl_wdata = (r_state == ddcc_pkg::ST_CLR) ? row_init() : r_row;

    always_ff @(posedge i_clk) begin
        if (ctl_we) r_ctl[ctl_waddr] <= ctl_wdata;
        r_ctl_q <= r_ctl[ctl_raddr];
        if (r_state == ddcc_pkg::ST_IDLE && i_req.valid) begin
            r_tag <= in_tag;
            r_set <= i_req.digest_w0[63 -: SET_BITS];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ddcc_pkg::ST_CLR:  if (r_clr == '1) n_state = ddcc_pkg::ST_IDLE;
            ddcc_pkg::ST_IDLE: if (i_req.valid) n_state = ddcc_pkg::ST_RD;
            ddcc_pkg::ST_RD:   n_state = ddcc_pkg::ST_CMP;
            ddcc_pkg::ST_CMP:
                if (r_row.used[r_way] && tag_rd == r_tag) n_state = ddcc_pkg::ST_WR;
                else if (r_way == t_way'(WAYS - 1)) n_state = ddcc_pkg::ST_DEC;
            ddcc_pkg::ST_DEC:
                if (!r_ins) n_state = ddcc_pkg::ST_WR;
                else if (r_row.cnt >= CW'(WAYS)) n_state = ddcc_pkg::ST_PICK;
                else n_state = ddcc_pkg::ST_WR;
            ddcc_pkg::ST_PICK_RD: n_state = ddcc_pkg::ST_PICK;
            ddcc_pkg::ST_PICK:
                if (!r_row.hv || r_row.cnt == '0 || r_step == SW'(2 * WAYS + 1))
                    n_state = ddcc_pkg::ST_WR;
                else if (!r_row.refb[r_row.hand]) n_state = ddcc_pkg::ST_REL;
            ddcc_pkg::ST_REL:
                if (r_picks == EVICT_W_L'(WAYS / 2)) n_state = ddcc_pkg::ST_WR;
                else n_state = ddcc_pkg::ST_PICK;
            ddcc_pkg::ST_WR:  n_state = ddcc_pkg::ST_OUT;
            ddcc_pkg::ST_OUT: if (o_rsp.ready) n_state = ddcc_pkg::ST_IDLE;
            default: n_state = ddcc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        t_way fw;
        t_way h;
        n_row = r_row;
        n_ins = r_ins;
        n_way = r_way;
        n_victim = r_victim;
        n_step = r_step;
        n_picks = r_picks;
        n_hit = r_hit;
        n_stored = r_stored;
        n_ev = r_ev;
        n_ovalid = 1'b0;
        tag_we = 1'b0;
        ctl_we = 1'b0;
        fw = '0;
        h = r_row.hand;
        unique case (r_state)
            ddcc_pkg::ST_CLR: ctl_we = 1'b1;
            ddcc_pkg::ST_IDLE: begin
                n_ins = i_req.req_type;
                n_way = '0;
                n_hit = 1'b0;
                n_stored = 1'b0;
                n_ev = '0;
                n_step = '0;
                n_picks = '0;
            end
            ddcc_pkg::ST_RD: begin
                n_row = r_ctl_q;
            end
            ddcc_pkg::ST_CMP: begin
                if (r_row.used[r_way] && tag_rd == r_tag) begin
                    n_hit = 1'b1;
                    n_row.refb[r_way] = 1'b1;
                end else begin
                    n_way = r_way + 1'b1;
                end
            end
            ddcc_pkg::ST_DEC: begin
                if (r_ins && r_row.cnt < CW'(WAYS)) begin
                    n_row = take_free(r_row, fw);
                    n_victim = fw;
                    n_row.refb[fw] = 1'b1;
                    n_stored = 1'b1;
                    tag_we = 1'b1;
                end
            end
            ddcc_pkg::ST_PICK: begin
                if (r_row.hv && r_row.cnt != '0 && r_step != SW'(2 * WAYS + 1)) begin
                    n_row.hand = next_after(r_row, h);
                    n_step = r_step + 1'b1;
                    if (r_row.refb[h]) n_row.refb[h] = 1'b0;
                    else n_victim = h;
                end
            end
            ddcc_pkg::ST_REL: begin
                n_step = '0;
                n_picks = r_picks + 1'b1;
                n_ev = r_ev + 1'b1;
                if (r_picks == '0) begin
                    n_row.refb[r_victim] = 1'b1;
                    n_stored = 1'b1;
                    tag_we = 1'b1;
                end else begin
                    n_row = release_way(r_row, r_victim);
                end
            end
            ddcc_pkg::ST_WR: begin
                ctl_we = 1'b1;
                n_ovalid = 1'b1;
            end
            ddcc_pkg::ST_OUT: n_ovalid = !o_rsp.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddcc_pkg::ST_CLR;
            r_clr <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
            if (r_state == ddcc_pkg::ST_CLR) r_clr <= r_clr + 1'b1;
        end
        r_row <= n_row;
        r_ins <= n_ins;
        r_way <= n_way;
        r_victim <= n_victim;
        r_step <= n_step;
        r_picks <= n_picks;
        r_hit <= n_hit;
        r_stored <= n_stored;
        r_ev <= n_ev;
    end

    assign i_req.ready = (r_state == ddcc_pkg::ST_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.hit = r_hit;
    assign o_rsp.stored = r_stored;
    assign o_rsp.evicted_count = r_ev;
endmodule

@@ rtl/ddcc_tag_ram.sv @@
// Tag memory: one entry per way of each set, registered read.
module ddcc_tag_ram #(
    parameter int unsigned AW = 15,
    parameter int unsigned DW = 256
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/ddcc_checker.sv @@
// Port-level checker for the digest dedup clock cache, bound to the top level.
`include "digest_dedup_clock_cache_assert.svh"
module ddcc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       req_type,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       rsp_hit,
    input logic       rsp_stored,
    input logic [2:0] rsp_ev
);
    `DDC_ASSERT_NEVER(a_hit_stored, i_clk, i_rst_n, rsp_valid && rsp_hit && rsp_stored, "hit and stored")
    `DDC_ASSERT_NEVER(a_ev_nostore, i_clk, i_rst_n, rsp_valid && !rsp_stored && rsp_ev != 3'd0, "eviction without store")
    `DDC_ASSERT_NEVER(a_busy, i_clk, i_rst_n, rsp_valid && req_ready, "ready while result pending")
    `DDC_ASSERT_IMPL(a_acc_busy, i_clk, i_rst_n, req_valid && req_ready |=> !req_ready, "accepted twice")
    `DDC_ASSERT_IMPL(a_hold, i_clk, i_rst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ev), "result dropped")
endmodule

bind digest_dedup_clock_cache ddcc_checker u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .req_valid(i_req.valid),
    .req_ready(i_req.ready),
    .req_type (i_req.req_type),
    .rsp_valid(o_rsp.valid),
    .rsp_ready(o_rsp.ready),
    .rsp_hit  (o_rsp.hit),
    .rsp_stored(o_rsp.stored),
    .rsp_ev   (o_rsp.evicted_count)
);

@@ bench/ddcc_checker.sv @@
// Checker: watches request/response channels, predicts each result and compares.
module ddcc_scoreboard (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ddcc_req_if        req,
    ddcc_rsp_if        rsp,
    output int         o_errors,
    output int         o_pending,
    output int         o_hits,
    output int         o_evicts
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NWAY = 8;
    localparam int NSET = 4096;
    localparam int SBITS = 12;

    typedef struct packed {
        logic       hit;
        logic       stored;
        logic [2:0] evicted_count;
    } t_result;

    logic [255:0] tag_q   [NSET][NWAY];
    bit           valid_q [NSET][NWAY];
    bit           refbit  [NSET][NWAY];
    bit   [2:0]   lru_ord [NSET][NWAY];
    bit   [2:0]   free_ord[NSET][NWAY];
    int           nused   [NSET];
    bit   [2:0]   hand    [NSET];
    bit           hand_on [NSET];

    t_result result_q[$];

    initial begin
        for (int s = 0; s < NSET; s++) begin
            nused[s] = 0;
            hand[s] = '0;
            hand_on[s] = 0;
            for (int w = 0; w < NWAY; w++) begin
                valid_q[s][w] = 0;
                refbit[s][w] = 0;
                lru_ord[s][w] = '0;
                free_ord[s][w] = 3'(w);
            end
        end
        o_errors = 0;
        o_hits = 0;
        o_evicts = 0;
    end

    function automatic int order_pos(int s, int w);
        for (int p = 0; p < nused[s] && p < NWAY; p++)
            if (lru_ord[s][p] == 3'(w)) return p;
        return -1;
    endfunction

    function automatic bit [2:0] way_after(int s, int w);
        int p;
        p = order_pos(s, w);
        if (p >= 0 && p + 1 < nused[s]) return lru_ord[s][p + 1];
        return lru_ord[s][0];
    endfunction

    function automatic int sweep_hand(int s);
        int h;
        if (!hand_on[s] || nused[s] == 0) return -1;
        for (int i = 0; i < 2 * NWAY + 1; i++) begin
            h = hand[s];
            hand[s] = way_after(s, h);
            if (!refbit[s][h]) return h;
            refbit[s][h] = 0;
        end
        return -1;
    endfunction

    function automatic void free_way(int s, int w);
        int p;
        int cnt;
        cnt = nused[s];
        p = order_pos(s, w);
        if (p < 0) return;
        if (hand_on[s] && hand[s] == 3'(w)) hand[s] = way_after(s, w);
        for (int q = p; q + 1 < cnt; q++) lru_ord[s][q] = lru_ord[s][q + 1];
        free_ord[s][NWAY - cnt] = 3'(w);
        nused[s] = cnt - 1;
        valid_q[s][w] = 0;
        if (cnt - 1 == 0) hand_on[s] = 0;
    endfunction

    function automatic int alloc_way(int s);
        int cnt;
        int w;
        cnt = nused[s];
        w = free_ord[s][0];
        for (int q = 0; q + 1 < NWAY - cnt; q++) free_ord[s][q] = free_ord[s][q + 1];
        lru_ord[s][cnt] = 3'(w);
        nused[s] = cnt + 1;
        valid_q[s][w] = 1;
        if (cnt == 0) begin
            hand[s] = 3'(w);
            hand_on[s] = 1;
        end
        return w;
    endfunction

    function automatic t_result dedup_predict(ddcc_pkg::t_req kind, logic [63:0] w0,
                                              logic [63:0] w1, logic [63:0] w2,
                                              logic [63:0] w3);
        t_result r;
        logic [255:0] tag;
        int s;
        int victim;
        int v;
        bit full;
        r = '0;
        tag = {w0 & ({64{1'b1}} >> SBITS), w1, w2, w3};
        s = int'(w0[63 -: SBITS]);
        for (int w = 0; w < NWAY; w++) begin
            if (valid_q[s][w] && tag_q[s][w] == tag) begin
                refbit[s][w] = 1;
                r.hit = 1;
                break;
            end
        end
        if (kind == ddcc_pkg::REQ_INSERT && !r.hit) begin
            full = nused[s] >= NWAY;
            if (!full) begin
                victim = alloc_way(s);
            end else begin
                victim = sweep_hand(s);
                if (victim >= 0) r.evicted_count = 1;
            end
            if (victim >= 0) begin
                tag_q[s][victim] = tag;
                refbit[s][victim] = 1;
                r.stored = 1;
                if (full) begin
                    for (int i = 0; i < NWAY / 2; i++) begin
                        v = sweep_hand(s);
                        if (v < 0) break;
                        free_way(s, v);
                        r.evicted_count++;
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result exp_r;
        t_result got;
        if (i_rst_n) begin
            if (req.valid && req.ready)
                result_q.push_back(dedup_predict(ddcc_pkg::t_req'(req.req_type),
                                                 req.digest_w0, req.digest_w1,
                                                 req.digest_w2, req.digest_w3));
            if (rsp.valid && rsp.ready) begin
                got = '{rsp.hit, rsp.stored, rsp.evicted_count};
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected transaction hit=%0b stored=%0b evicted=%0d",
                             $time, got.hit, got.stored, got.evicted_count);
                    o_errors++;
                end else begin
                    exp_r = result_q.pop_front();
                    if (got !== exp_r) begin
                        $display({"%0t: mismatch expected hit=%0b stored=%0b evicted=%0d,",
                                  " got hit=%0b stored=%0b evicted=%0d"},
                                 $time, exp_r.hit, exp_r.stored, exp_r.evicted_count,
                                 got.hit, got.stored, got.evicted_count);
                        o_errors++;
                    end
                    if (exp_r.hit) o_hits++;
                    if (exp_r.evicted_count != 0) o_evicts++;
                end
            end
        end
        o_pending = result_q.size();
    end
endmodule

@@ bench/tb_top.sv @@
// Testbench top: clock, reset, request stimulus, response stalls and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending, hits, evicts;
    bit   calm;

    logic [63:0] set_pool[8];
    logic [255:0] tag_pool[16];

    ddcc_req_if req ();
    ddcc_rsp_if rsp ();

    digest_dedup_clock_cache u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .o_rsp  (rsp)
    );

    ddcc_scoreboard u_chk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .req      (req),
        .rsp      (rsp),
        .o_errors (errors),
        .o_pending(pending),
        .o_hits   (hits),
        .o_evicts (evicts)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic send(ddcc_pkg::t_req kind, logic [63:0] w0, logic [63:0] w1,
                        logic [63:0] w2, logic [63:0] w3);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid     <= 1'b1;
        req.req_type  <= kind;
        req.digest_w0 <= w0;
        req.digest_w1 <= w1;
        req.digest_w2 <= w2;
        req.digest_w3 <= w3;
        do @(posedge i_clk); while (!(req.valid && req.ready));
    endtask

    task automatic send_pool(ddcc_pkg::t_req kind, int si, int ti);
        logic [255:0] t;
        t = tag_pool[ti];
        send(kind, {set_pool[si][63:52], t[255:204]}, t[191:128], t[127:64], t[63:0]);
    endtask

    // response side stalls
    initial begin
        int stall;
        stall = 0;
        rsp.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (stall > 0) begin
                rsp.ready <= 1'b0;
                stall--;
            end else begin
                rsp.ready <= 1'b1;
                stall = idle_len();
            end
            @(posedge i_clk);
        end
    end

    initial begin
        int r;
        calm = 0;
        i_rst_n       <= 1'b0;
        req.valid     <= 1'b0;
        req.req_type  <= ddcc_pkg::REQ_LOOKUP;
        req.digest_w0 <= '0;
        req.digest_w1 <= '0;
        req.digest_w2 <= '0;
        req.digest_w3 <= '0;
        set_pool[0] = '0;
        set_pool[1] = '1;
        for (int i = 2; i < 8; i++) set_pool[i] = {$urandom, $urandom};
        for (int i = 0; i < 16; i++)
            tag_pool[i] = {$urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty lookup, extremes, hit on insert, fill and evict
        send(ddcc_pkg::REQ_LOOKUP, '0, '0, '0, '0);
        send(ddcc_pkg::REQ_INSERT, '0, '0, '0, '0);
        send(ddcc_pkg::REQ_LOOKUP, '0, '0, '0, '0);
        send(ddcc_pkg::REQ_INSERT, '1, '1, '1, '1);
        send(ddcc_pkg::REQ_INSERT, '1, '1, '1, '1);
        send(ddcc_pkg::REQ_LOOKUP, '1, '1, '1, '1);
        send(ddcc_pkg::REQ_LOOKUP, '1, '1, '1, 64'hFFFF_FFFF_FFFF_FFFE);
        for (int i = 0; i < 8; i++) send_pool(ddcc_pkg::REQ_INSERT, 2, i);
        send_pool(ddcc_pkg::REQ_LOOKUP, 2, 3);
        send_pool(ddcc_pkg::REQ_INSERT, 2, 8);
        send_pool(ddcc_pkg::REQ_INSERT, 2, 9);
        for (int i = 0; i < 4; i++) send_pool(ddcc_pkg::REQ_LOOKUP, 2, i);

        // random: mostly traffic into a few hot sets so they fill and evict
        for (int n = 0; n < 1700; n++) begin
            if (n % 300 == 0) calm = ($urandom_range(3) == 0);
            r = $urandom_range(99);
            if (r < 12)
                send(ddcc_pkg::t_req'($urandom_range(1)), {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
            else
                send_pool(($urandom_range(99) < 60) ? ddcc_pkg::REQ_INSERT
                                                    : ddcc_pkg::REQ_LOOKUP,
                          $urandom_range(7), $urandom_range(15));
        end
        req.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Ran about 1720 lookups/inserts over hot and random sets with random stalls.");
        $display("Hits seen: %0d, inserts with evictions: %0d.", hits, evicts);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/ddcc_pkg.sv
rtl/ddcc_if.sv
rtl/ddcc_tag_ram.sv
rtl/digest_dedup_clock_cache.sv
rtl/ddcc_checker.sv
bench/ddcc_checker.sv
bench/tb_top.sv
